// ===== hdl/kct_pkg.sv =====
`timescale 1ns / 1ps

package kct_pkg;

   localparam int SLOTS   = 16;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int KEY_W   = 32;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int ROW_W   = KEY_W + COLOR_W;
   localparam int REQ_W   = 2;
   localparam int STAT_W  = 2;
   localparam int USED_W  = 5;

   typedef logic [REQ_W-1:0]  req_code_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam req_code_type REQ_LOOKUP = 2'd0;
   localparam req_code_type REQ_ADDMOD = 2'd1;
   localparam req_code_type REQ_DELETE = 2'd2;

   localparam status_type STAT_OK        = 2'd0;
   localparam status_type STAT_EMPTY     = 2'd1;
   localparam status_type STAT_NOT_FOUND = 2'd2;
   localparam status_type STAT_FULL      = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_MOVE,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/kct_if.sv =====
`timescale 1ns / 1ps

interface kct_req_if;
   logic                         valid;
   logic                         ready;
   logic [kct_pkg::REQ_W-1:0]    req_type;
   logic [kct_pkg::KEY_W-1:0]    key;
   logic [kct_pkg::CHAN_W-1:0]   red_in;
   logic [kct_pkg::CHAN_W-1:0]   green_in;
   logic [kct_pkg::CHAN_W-1:0]   blue_in;

   modport source (output valid, req_type, key, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, req_type, key, red_in, green_in, blue_in, output ready);
endinterface

interface kct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kct_pkg::STAT_W-1:0]   status;
   logic [kct_pkg::CHAN_W-1:0]   red_out;
   logic [kct_pkg::CHAN_W-1:0]   green_out;
   logic [kct_pkg::CHAN_W-1:0]   blue_out;
   logic [kct_pkg::USED_W-1:0]   entries_used;

   modport source (output valid, status, red_out, green_out, blue_out, entries_used,
                   input ready);
   modport sink   (input valid, status, red_out, green_out, blue_out, entries_used,
                   output ready);
endinterface

// ===== hdl/keyed_color_table.sv =====
`timescale 1ns / 1ps

// Keyed color table: up to SLOTS entries of {32-bit key, 24-bit RGB}, kept
// densely packed in slots 0..count-1 of one single-port-read RAM.
// req_ch takes one beat per request (lookup, add-or-modify, delete); rsp_ch
// returns exactly one beat per request with status, color and entry count.
// Requests are handled one at a time. req_ch.ready is high only while the
// block is idle and out of reset. A request scans the RAM one slot per cycle,
// stopping at the first matching key or at the last valid slot; it scans
// no slot when the table is empty and at most SLOTS slots otherwise. A
// delete that moves the last entry into the freed slot passes through an
// extra move state. The result is registered: rsp_ch.valid
// rises the cycle after the request finishes, and the next request is
// accepted in that same cycle. If the receiver stalls, the result stays in
// the output register and one more request may be processed; its result then
// waits until the output register drains. Reset empties the table (the count
// goes to zero; the RAM itself is not cleared) and drops any pending result.

module keyed_color_table (
   input  logic           clock,
   input  logic           reset,
   kct_req_if.sink        req_ch,
   kct_rsp_if.source      rsp_ch
);

   kct_pkg::state_type                 state_ff, state_in;
   kct_pkg::req_code_type              req_type_ff, req_type_in;
   logic [kct_pkg::KEY_W-1:0]          key_ff, key_in;
   logic [kct_pkg::COLOR_W-1:0]        color_ff, color_in;
   logic [kct_pkg::IDX_W-1:0]          pend_idx_ff, pend_idx_in;
   logic [kct_pkg::CNT_W-1:0]          count_ff, count_in;
   logic                               hit_ff, hit_in;
   logic [kct_pkg::IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   logic [kct_pkg::COLOR_W-1:0]        hit_color_ff, hit_color_in;
   kct_pkg::status_type                res_status_ff, res_status_in;
   logic [kct_pkg::COLOR_W-1:0]        res_color_ff, res_color_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   kct_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [kct_pkg::COLOR_W-1:0]        rsp_color_ff, rsp_color_in;
   logic [kct_pkg::USED_W-1:0]         rsp_used_ff, rsp_used_in;

   logic                               ram_wr_en;
   logic [kct_pkg::IDX_W-1:0]          ram_wr_addr;
   logic [kct_pkg::ROW_W-1:0]          ram_wr_data;
   logic                               ram_rd_en;
   logic [kct_pkg::IDX_W-1:0]          ram_rd_addr;
   logic [kct_pkg::ROW_W-1:0]          ram_rd_data;

   logic                               accept;
   logic                               key_match;
   logic                               scan_last;
   logic                               out_free;
   logic                               is_full;
   logic [kct_pkg::IDX_W-1:0]          last_idx;
   logic                               move_needed;

   kct_ram #(
      .WIDTH (kct_pkg::ROW_W),
      .DEPTH (kct_pkg::SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == kct_pkg::ST_IDLE) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign key_match = (ram_rd_data[kct_pkg::ROW_W-1:kct_pkg::COLOR_W] == key_ff);
   assign scan_last = ((kct_pkg::CNT_W'(pend_idx_ff) + kct_pkg::CNT_W'(1)) == count_ff);
   assign is_full   = (count_ff == kct_pkg::CNT_W'(kct_pkg::SLOTS));
   assign last_idx  = kct_pkg::IDX_W'(count_ff - kct_pkg::CNT_W'(1));
   // delete hit on any slot but the last one pulls the last entry down
   assign move_needed = (req_type_ff == kct_pkg::REQ_DELETE) && hit_ff
                        && (hit_idx_ff != last_idx);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kct_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (count_ff == '0) ? kct_pkg::ST_EXEC : kct_pkg::ST_SCAN;
            end
         end
         kct_pkg::ST_SCAN: begin
            if (key_match || scan_last) begin
               state_in = kct_pkg::ST_EXEC;
            end
         end
         kct_pkg::ST_EXEC: begin
            state_in = move_needed ? kct_pkg::ST_MOVE : kct_pkg::ST_RESP;
         end
         kct_pkg::ST_MOVE: begin
            state_in = kct_pkg::ST_RESP;
         end
         kct_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = kct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kct_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_type_in   = req_type_ff;
      key_in        = key_ff;
      color_in      = color_ff;
      pend_idx_in   = pend_idx_ff;
      count_in      = count_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_color_in  = hit_color_ff;
      res_status_in = res_status_ff;
      res_color_in  = res_color_ff;
      rsp_status_in = rsp_status_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = {key_ff, color_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      unique case (state_ff)
         kct_pkg::ST_IDLE: begin
            if (accept) begin
               req_type_in = req_ch.req_type;
               key_in      = req_ch.key;
               color_in    = {req_ch.red_in, req_ch.green_in, req_ch.blue_in};
               pend_idx_in = '0;
               hit_in      = 1'b0;
               ram_rd_en   = 1'b1;
            end
         end
         kct_pkg::ST_SCAN: begin
            // compare slot pend_idx, prefetch the next slot
            ram_rd_en   = 1'b1;
            ram_rd_addr = pend_idx_ff + kct_pkg::IDX_W'(1);
            pend_idx_in = pend_idx_ff + kct_pkg::IDX_W'(1);
            if (key_match) begin
               hit_in       = 1'b1;
               hit_idx_in   = pend_idx_ff;
               hit_color_in = ram_rd_data[kct_pkg::COLOR_W-1:0];
            end
         end
         kct_pkg::ST_EXEC: begin
            res_status_in = kct_pkg::STAT_OK;
            res_color_in  = '0;
            case (req_type_ff)
               kct_pkg::REQ_ADDMOD: begin
                  if (hit_ff) begin
                     ram_wr_en = 1'b1;
                  end else if (is_full) begin
                     res_status_in = kct_pkg::STAT_FULL;
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = kct_pkg::IDX_W'(count_ff);
                     count_in    = count_ff + kct_pkg::CNT_W'(1);
                  end
               end
               kct_pkg::REQ_DELETE: begin
                  if (count_ff == '0) begin
                     res_status_in = kct_pkg::STAT_EMPTY;
                  end else if (!hit_ff) begin
                     res_status_in = kct_pkg::STAT_NOT_FOUND;
                  end else begin
                     count_in    = count_ff - kct_pkg::CNT_W'(1);
                     ram_rd_en   = move_needed;
                     ram_rd_addr = last_idx;
                  end
               end
               default: begin
                  if (hit_ff) begin
                     res_color_in = hit_color_ff;
                  end else begin
                     res_status_in = kct_pkg::STAT_NOT_FOUND;
                  end
               end
            endcase
         end
         kct_pkg::ST_MOVE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data;
         end
         kct_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_color_in  = res_color_ff;
               rsp_used_in   = kct_pkg::USED_W'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kct_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
      req_type_ff   <= req_type_in;
      key_ff        <= key_in;
      color_ff      <= color_in;
      pend_idx_ff   <= pend_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_color_ff  <= hit_color_in;
      res_status_ff <= res_status_in;
      res_color_ff  <= res_color_in;
      rsp_status_ff <= rsp_status_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.red_out      = rsp_color_ff[3*kct_pkg::CHAN_W-1:2*kct_pkg::CHAN_W];
   assign rsp_ch.green_out    = rsp_color_ff[2*kct_pkg::CHAN_W-1:kct_pkg::CHAN_W];
   assign rsp_ch.blue_out     = rsp_color_ff[kct_pkg::CHAN_W-1:0];
   assign rsp_ch.entries_used = rsp_used_ff;

endmodule

// ===== hdl/kct_ram.sv =====
`timescale 1ns / 1ps

module kct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/kct_checker.sv =====
`timescale 1ns / 1ps

module kct_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [kct_pkg::STAT_W-1:0]    rsp_status,
   input logic [kct_pkg::CHAN_W-1:0]    rsp_red,
   input logic [kct_pkg::CHAN_W-1:0]    rsp_green,
   input logic [kct_pkg::CHAN_W-1:0]    rsp_blue,
   input logic [kct_pkg::USED_W-1:0]    rsp_used
);

   // a stalled beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_color_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != kct_pkg::STAT_OK)
      |-> (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0))
      else $error("color on a failed request");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == kct_pkg::STAT_EMPTY) |-> (rsp_used == '0))
      else $error("empty status with entries in use");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == kct_pkg::STAT_FULL)
      |-> (rsp_used == kct_pkg::USED_W'(kct_pkg::SLOTS)))
      else $error("full status with free slots");

endmodule

bind keyed_color_table kct_checker u_kct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_red    (rsp_ch.red_out),
   .rsp_green  (rsp_ch.green_out),
   .rsp_blue   (rsp_ch.blue_out),
   .rsp_used   (rsp_ch.entries_used)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import kct_pkg::*;

   // req_type 3 is unused by the block and is handled like a lookup
   localparam req_code_type REQ_SPARE = 2'd3;

   localparam int N_DIR          = 25;
   localparam int RAND_PER_PHASE = 425;
   localparam int KEY_POOL_N     = 20;
   localparam int BIAS_PERIOD    = 60;
   localparam int LONG_STALL     = 300;
   localparam int DRAIN_CYCLES   = 4 * (SLOTS + 4);

   typedef struct packed {
      req_code_type      op;
      logic [KEY_W-1:0]  key;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } table_req_type;

   typedef struct packed {
      status_type        status;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [USED_W-1:0] used;
   } table_rsp_type;

   typedef struct packed {
      table_req_type req;
      logic          typed;
      table_rsp_type rsp;
   } dir_row_type;

   // Rows with typed = 0 are checked against the table predictor.
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{'{REQ_LOOKUP, 32'h0000_0000, '0, '0, '0}, 1'b1, '{STAT_NOT_FOUND, '0, '0, '0, 5'd0}},
      '{'{REQ_DELETE, 32'hFFFF_FFFF, '0, '0, '0}, 1'b1, '{STAT_EMPTY, '0, '0, '0, 5'd0}},
      '{'{REQ_ADDMOD, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd1}},
      '{'{REQ_ADDMOD, 32'h0000_0000, 8'h00, 8'h00, 8'h00}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd2}},
      '{'{REQ_ADDMOD, 32'h0000_0001, 8'h01, 8'h02, 8'h04}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd3}},
      '{'{REQ_ADDMOD, 32'h8000_0000, 8'h80, 8'h40, 8'h20}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd4}},
      '{'{REQ_ADDMOD, 32'h5555_5555, 8'h55, 8'hAA, 8'h55}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd5}},
      '{'{REQ_ADDMOD, 32'hAAAA_AAAA, 8'hAA, 8'h55, 8'hAA}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd6}},
      '{'{REQ_ADDMOD, 32'h1000_0007, 8'h07, 8'h70, 8'hC7}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd7}},
      '{'{REQ_ADDMOD, 32'h1000_0008, 8'h08, 8'h80, 8'hC8}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd8}},
      '{'{REQ_ADDMOD, 32'h1000_0009, 8'h09, 8'h90, 8'hC9}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd9}},
      '{'{REQ_ADDMOD, 32'h1000_000A, 8'h0A, 8'hA0, 8'hCA}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd10}},
      '{'{REQ_ADDMOD, 32'h1000_000B, 8'h0B, 8'hB0, 8'hCB}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd11}},
      '{'{REQ_ADDMOD, 32'h1000_000C, 8'h0C, 8'hC0, 8'hCC}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd12}},
      '{'{REQ_ADDMOD, 32'h1000_000D, 8'h0D, 8'hD0, 8'hCD}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd13}},
      '{'{REQ_ADDMOD, 32'h1000_000E, 8'h0E, 8'hE0, 8'hCE}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd14}},
      '{'{REQ_ADDMOD, 32'h1000_000F, 8'h0F, 8'hF0, 8'hCF}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd15}},
      '{'{REQ_ADDMOD, 32'h1000_0010, 8'h10, 8'h01, 8'hD0}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd16}},
      // full: modify of a present key still works, a new key is refused
      '{'{REQ_ADDMOD, 32'h0000_0000, 8'h5A, 8'hA5, 8'h3C}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd16}},
      '{'{REQ_ADDMOD, 32'h1234_5678, 8'h11, 8'h22, 8'h33}, 1'b1, '{STAT_FULL, '0, '0, '0, 5'd16}},
      '{'{REQ_SPARE, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
        '{STAT_OK, 8'h5A, 8'hA5, 8'h3C, 5'd16}},
      // slot 0 removed, last entry moves down into it
      '{'{REQ_DELETE, 32'hFFFF_FFFF, '0, '0, '0}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd15}},
      '{'{REQ_LOOKUP, 32'h1000_0010, '0, '0, '0}, 1'b0, '0},
      '{'{REQ_DELETE, 32'h1000_000F, '0, '0, '0}, 1'b1, '{STAT_OK, '0, '0, '0, 5'd14}},
      '{'{REQ_DELETE, 32'h1234_5678, '0, '0, '0}, 1'b1, '{STAT_NOT_FOUND, '0, '0, '0, 5'd14}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   kct_req_if req_ch ();
   kct_rsp_if rsp_ch ();

   keyed_color_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [KEY_W-1:0]   tbl_key   [SLOTS];
   logic [COLOR_W-1:0] tbl_color [SLOTS];
   int                 tbl_count = 0;

   table_rsp_type pending_rsp [$];

   int               fail_count    = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      rcv_idle_pct  = 0;
   int               stall_order   = 0;
   int unsigned      add_bias      = 80;
   logic [KEY_W-1:0] key_pool [KEY_POOL_N];

   function automatic table_rsp_type apply_request(input table_req_type r);
      table_rsp_type rsp;
      int            hit;
      rsp        = '0;
      rsp.status = STAT_OK;
      hit        = tbl_count;
      // lowest matching slot wins
      for (int i = tbl_count - 1; i >= 0; i--)
         if (tbl_key[i] == r.key) hit = i;
      case (r.op)
         REQ_ADDMOD: begin
            if (hit < tbl_count) begin
               tbl_color[hit] = {r.red, r.green, r.blue};
            end else if (tbl_count >= SLOTS) begin
               rsp.status = STAT_FULL;
            end else begin
               tbl_key[tbl_count]   = r.key;
               tbl_color[tbl_count] = {r.red, r.green, r.blue};
               tbl_count++;
            end
         end
         REQ_DELETE: begin
            if (tbl_count == 0) begin
               rsp.status = STAT_EMPTY;
            end else if (hit >= tbl_count) begin
               rsp.status = STAT_NOT_FOUND;
            end else begin
               tbl_count--;
               tbl_key[hit]   = tbl_key[tbl_count];
               tbl_color[hit] = tbl_color[tbl_count];
            end
         end
         default: begin
            if (hit < tbl_count) {rsp.red, rsp.green, rsp.blue} = tbl_color[hit];
            else rsp.status = STAT_NOT_FOUND;
         end
      endcase
      rsp.used = USED_W'(tbl_count);
      return rsp;
   endfunction

   // Mostly keys from a small pool so the table fills, hits and drains;
   // a few fresh random keys and all-zero / all-one keys as noise.
   function automatic table_req_type random_request();
      table_req_type r;
      int unsigned   pick;
      r.red   = CHAN_W'($urandom_range(255));
      r.green = CHAN_W'($urandom_range(255));
      r.blue  = CHAN_W'($urandom_range(255));
      pick    = $urandom_range(99);
      if (pick < 5) r.op = REQ_SPARE;
      else if (pick < 35) r.op = REQ_LOOKUP;
      else if ($urandom_range(99) < add_bias) r.op = REQ_ADDMOD;
      else r.op = REQ_DELETE;
      pick = $urandom_range(99);
      if (pick < 8) r.key = $urandom();
      else if (pick < 12) r.key = {KEY_W{pick[0]}};
      else r.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
      return r;
   endfunction

   task automatic offer_request(input table_req_type r, input logic typed,
                                input table_rsp_type typed_rsp);
      table_rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= r.op;
      req_ch.key      <= r.key;
      req_ch.red_in   <= r.red;
      req_ch.green_in <= r.green;
      req_ch.blue_in  <= r.blue;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = apply_request(r);
      pending_rsp.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic check_response();
      table_rsp_type want;
      if (pending_rsp.size() == 0) begin
         $error("response beat with no request pending");
         fail_count++;
      end else begin
         want = pending_rsp.pop_front();
         if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            fail_count++;
         end
         if (rsp_ch.red_out !== want.red) begin
            $error("red_out: expected %0h, got %0h", want.red, rsp_ch.red_out);
            fail_count++;
         end
         if (rsp_ch.green_out !== want.green) begin
            $error("green_out: expected %0h, got %0h", want.green, rsp_ch.green_out);
            fail_count++;
         end
         if (rsp_ch.blue_out !== want.blue) begin
            $error("blue_out: expected %0h, got %0h", want.blue, rsp_ch.blue_out);
            fail_count++;
         end
         if (rsp_ch.entries_used !== want.used) begin
            $error("entries_used: expected %0d, got %0d", want.used, rsp_ch.entries_used);
            fail_count++;
         end
      end
   endtask

   // response side: checks every beat and randomizes ready
   initial begin : rsp_sink
      int stall_left;
      int stall_served;
      stall_left   = 0;
      stall_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_response();
         if (stall_served != stall_order) begin
            stall_served = stall_order;
            stall_left   = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_LOOKUP;
      req_ch.key      = '0;
      req_ch.red_in   = '0;
      req_ch.green_in = '0;
      req_ch.blue_in  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < N_DIR; n++)
         offer_request(DIR_ROWS[n].req, DIR_ROWS[n].typed, DIR_ROWS[n].rsp);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 84 : 0;
         rcv_idle_pct  = (ph == 0) ? 84 : (ph == 1) ? 18 : 0;
         foreach (key_pool[i]) key_pool[i] = $urandom();
         // last phase: hold the response side off so the block backs up
         if (ph == 2) stall_order++;
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            // swing between fill-heavy and drain-heavy stretches
            if (n % BIAS_PERIOD == 0) add_bias = (add_bias > 50) ? 25 : 80;
            offer_request(random_request(), 1'b0, '0);
         end
      end
      req_ch.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== keyed_color_table.f =====
hdl/kct_pkg.sv
hdl/kct_if.sv
hdl/kct_ram.sv
hdl/keyed_color_table.sv
hdl/kct_checker.sv
tb/tb.sv
